// ===== sv/erpt_pkg.sv =====
package erpt_pkg;

    // Fixed field widths
    localparam int COORD_W  = 32;
    localparam int ANGLE_W  = 16;
    // CORDIC datapath width (Q2.30 with headroom) and step counter width
    localparam int CORDIC_W = 34;
    localparam int STEP_W   = 5;

    // Defaults for the top-level parameters
    localparam int CORDIC_STEPS_DEF     = 16;
    localparam int MATRIX_FRAC_BITS_DEF = 16;

    // CORDIC gain compensation, 0.6072529350 in Q2.30
    localparam logic [31:0] CORDIC_K = 32'd652032874;

    // Sequencing counts
    localparam int NUM_PROD      = 14;
    localparam int POSE_MUL_LAST = 15;
    localparam int POINT_LAST    = 10;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_SINCOS,
        ST_POSE_MUL,
        ST_POINT,
        ST_PUBLISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic              load_in;
        logic              cordic_step;
        logic [STEP_W-1:0] idx;
        logic              sc_load;
        logic              mul_en;
        logic              mul_pose;
        logic [3:0]        mul_sel;
        logic              wb_en;
        logic [3:0]        wb_sel;
        logic              pose_commit;
        logic              acc_en;
        logic              acc_first;
        logic              fin_en;
        logic [1:0]        fin_row;
        logic              publish;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
    } status_t;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10680862;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/erpt_ifs.sv =====
// Input beat channel: pose or point
interface erpt_item_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic signed [erpt_pkg::COORD_W-1:0]  coord_x;
    logic signed [erpt_pkg::COORD_W-1:0]  coord_y;
    logic signed [erpt_pkg::COORD_W-1:0]  coord_z;
    logic        [erpt_pkg::ANGLE_W-1:0]  angle_about_x;
    logic        [erpt_pkg::ANGLE_W-1:0]  angle_about_y;
    logic        [erpt_pkg::ANGLE_W-1:0]  angle_about_z;

    modport source (output valid, mode, coord_x, coord_y, coord_z,
                    angle_about_x, angle_about_y, angle_about_z, input ready);
    modport sink   (input valid, mode, coord_x, coord_y, coord_z,
                    angle_about_x, angle_about_y, angle_about_z, output ready);
endinterface

// Output beat channel: transformed point
interface erpt_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [erpt_pkg::COORD_W-1:0]  out_x;
    logic signed [erpt_pkg::COORD_W-1:0]  out_y;
    logic signed [erpt_pkg::COORD_W-1:0]  out_z;
    logic                                 overflow;

    modport source (output valid, out_x, out_y, out_z, overflow, input ready);
    modport sink   (input valid, out_x, out_y, out_z, overflow, output ready);
endinterface

// ===== sv/erpt_ctrl.sv =====
module erpt_ctrl #(
    parameter int CORDIC_STEPS = erpt_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_mode,
    output logic               in_ready,
    input  erpt_pkg::status_t  status,
    output erpt_pkg::cmd_t     cmd
);

    localparam logic [erpt_pkg::STEP_W-1:0] CORDIC_LAST =
        erpt_pkg::STEP_W'(CORDIC_STEPS - 1);
    localparam logic [erpt_pkg::STEP_W-1:0] POSE_LAST =
        erpt_pkg::STEP_W'(erpt_pkg::POSE_MUL_LAST);
    localparam logic [erpt_pkg::STEP_W-1:0] PT_LAST =
        erpt_pkg::STEP_W'(erpt_pkg::POINT_LAST);
    localparam logic [erpt_pkg::STEP_W-1:0] PROD_LAST =
        erpt_pkg::STEP_W'(erpt_pkg::NUM_PROD - 1);

    erpt_pkg::state_t            state_reg, state_next;
    logic [erpt_pkg::STEP_W-1:0] cnt_reg, cnt_next;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= erpt_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 1'b1;
        case (state_reg)
            erpt_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = in_mode ? erpt_pkg::ST_POINT : erpt_pkg::ST_CORDIC;
                end
            end
            erpt_pkg::ST_CORDIC:
            begin
                if (cnt_reg == CORDIC_LAST)
                begin
                    state_next = erpt_pkg::ST_SINCOS;
                end
            end
            erpt_pkg::ST_SINCOS:
            begin
                state_next = erpt_pkg::ST_POSE_MUL;
                cnt_next   = '0;
            end
            erpt_pkg::ST_POSE_MUL:
            begin
                if (cnt_reg == POSE_LAST)
                begin
                    state_next = erpt_pkg::ST_IDLE;
                end
            end
            erpt_pkg::ST_POINT:
            begin
                if (cnt_reg == PT_LAST)
                begin
                    state_next = erpt_pkg::ST_PUBLISH;
                end
            end
            erpt_pkg::ST_PUBLISH:
            begin
                cnt_next = '0;
                if (status.out_free)
                begin
                    state_next = erpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = erpt_pkg::ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        cmd.idx  = cnt_reg;
        case (state_reg)
            erpt_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            erpt_pkg::ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
            end
            erpt_pkg::ST_SINCOS:
            begin
                cmd.sc_load = 1'b1;
            end
            erpt_pkg::ST_POSE_MUL:
            begin
                // multiply into mul_reg at step k, then write the registered product back
                cmd.mul_pose    = 1'b1;
                cmd.mul_en      = (cnt_reg <= PROD_LAST);
                cmd.mul_sel     = cnt_reg[3:0];
                cmd.wb_en       = (cnt_reg != '0) && (cnt_reg <= PROD_LAST + 1'b1);
                cmd.wb_sel      = 4'(cnt_reg - 1'b1);
                cmd.pose_commit = (cnt_reg == POSE_LAST);
            end
            erpt_pkg::ST_POINT:
            begin
                cmd.mul_en    = (cnt_reg <= 5'd8);
                cmd.mul_sel   = cnt_reg[3:0];
                cmd.acc_en    = (cnt_reg >= 5'd1) && (cnt_reg <= 5'd9);
                cmd.acc_first = (cnt_reg == 5'd1) || (cnt_reg == 5'd4) || (cnt_reg == 5'd7);
                cmd.fin_en    = (cnt_reg == 5'd4) || (cnt_reg == 5'd7) || (cnt_reg == 5'd10);
                case (cnt_reg)
                    5'd4:    cmd.fin_row = 2'd0;
                    5'd7:    cmd.fin_row = 2'd1;
                    default: cmd.fin_row = 2'd2;
                endcase
            end
            erpt_pkg::ST_PUBLISH:
            begin
                cmd.publish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== sv/erpt_datapath.sv =====
module erpt_datapath #(
    parameter int MATRIX_FRAC_BITS = erpt_pkg::MATRIX_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  erpt_pkg::cmd_t                      cmd,
    output erpt_pkg::status_t                   status,
    input  logic signed [erpt_pkg::COORD_W-1:0] coord_x,
    input  logic signed [erpt_pkg::COORD_W-1:0] coord_y,
    input  logic signed [erpt_pkg::COORD_W-1:0] coord_z,
    input  logic        [erpt_pkg::ANGLE_W-1:0] angle_about_x,
    input  logic        [erpt_pkg::ANGLE_W-1:0] angle_about_y,
    input  logic        [erpt_pkg::ANGLE_W-1:0] angle_about_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [erpt_pkg::COORD_W-1:0] out_x,
    output logic signed [erpt_pkg::COORD_W-1:0] out_y,
    output logic signed [erpt_pkg::COORD_W-1:0] out_z,
    output logic                                overflow
);

    localparam int F   = MATRIX_FRAC_BITS;
    localparam int EW  = F + 2;
    localparam int CW  = erpt_pkg::CORDIC_W;
    localparam int XW  = erpt_pkg::COORD_W;
    localparam int PW  = XW + EW;
    localparam int AW  = PW + 2;
    localparam int SH  = 30 - F;

    localparam logic signed [CW-1:0] RND_SC  = CW'((2 ** SH) / 2);
    localparam logic signed [CW-1:0] QTR     = CW'(64'sd1 << 30);
    localparam logic signed [CW-1:0] HALF    = CW'(64'sd1 << 31);
    localparam logic signed [PW-1:0] RND_MP  = PW'(64'sd1 << (F - 1));
    localparam logic signed [AW-1:0] RND_AC  = AW'(64'sd1 << (F - 1));
    localparam logic signed [EW:0]   ONE_E   = (EW + 1)'(64'sd1 << F);
    localparam logic signed [AW-1:0] MAX_OUT = AW'(64'sd2147483647);
    localparam logic signed [AW-1:0] MIN_OUT = -AW'(64'sd2147483648);

    // Clamp a sum of matrix terms to [-1, 1]
    function automatic logic signed [EW-1:0] clamp_e(input logic signed [EW:0] v);
        logic signed [EW-1:0] r;
        if (v > ONE_E)
            r = EW'(ONE_E);
        else if (v < -ONE_E)
            r = EW'(-ONE_E);
        else
            r = EW'(v);
        return r;
    endfunction

    // Round a Q2.30 CORDIC value to Q1.F and clamp
    function automatic logic signed [EW-1:0] round_sc(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] one;
        logic signed [EW-1:0] r;
        one = CW'(64'sd1 << F);
        s = (v + RND_SC) >>> SH;
        if (s > one)
            r = EW'(one);
        else if (s < -one)
            r = EW'(-one);
        else
            r = EW'(s);
        return r;
    endfunction

    // Input latch
    logic signed [XW-1:0] pt_reg [3];

    // CORDIC lanes: 0 about x, 1 about y, 2 about z
    logic signed [CW-1:0] cx_reg [3];
    logic signed [CW-1:0] cy_reg [3];
    logic signed [CW-1:0] cz_reg [3];
    logic        [2:0]    cneg_reg;
    logic        [erpt_pkg::ANGLE_W-1:0] ang [3];

    // Sines and cosines, Q1.F
    logic signed [EW-1:0] cos_reg [3];
    logic signed [EW-1:0] sin_reg [3];

    // Shared multiplier
    logic signed [XW-1:0] mul_a;
    logic signed [EW-1:0] mul_b;
    logic signed [PW-1:0] mul_reg, mul_next;
    logic signed [PW-1:0] mul_rnd;

    // Pose products and pose state
    logic signed [EW-1:0] prod_reg [erpt_pkg::NUM_PROD];
    logic signed [EW-1:0] rot_reg [9];
    logic signed [XW-1:0] trans_reg [3];

    // Point accumulation and results
    logic signed [AW-1:0] acc_reg;
    logic signed [AW-1:0] mul_ext;
    logic signed [AW-1:0] fin_val;
    logic signed [XW-1:0] res_reg [3];
    logic                 ovf_reg;
    logic signed [XW-1:0] fin_sat;
    logic                 fin_ovf;

    logic                 out_valid_reg;
    logic signed [XW-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                 overflow_reg;

    assign ang[0] = angle_about_x;
    assign ang[1] = angle_about_y;
    assign ang[2] = angle_about_z;

    // Input latch
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            pt_reg[0] <= coord_x;
            pt_reg[1] <= coord_y;
            pt_reg[2] <= coord_z;
        end
    end

    // CORDIC: quadrant fold on load, one rotation step per cycle
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 3; l++)
        begin
            logic signed [CW-1:0] z0;
            logic signed [CW-1:0] at;
            z0 = CW'(signed'({ang[l], 16'b0}));
            at = CW'(signed'({1'b0, erpt_pkg::atan_turn(cmd.idx)}));
            if (cmd.load_in)
            begin
                cx_reg[l] <= CW'(signed'({1'b0, erpt_pkg::CORDIC_K}));
                cy_reg[l] <= '0;
                if (z0 > QTR)
                begin
                    cz_reg[l]   <= z0 - HALF;
                    cneg_reg[l] <= 1'b1;
                end
                else if (z0 < -QTR)
                begin
                    cz_reg[l]   <= z0 + HALF;
                    cneg_reg[l] <= 1'b1;
                end
                else
                begin
                    cz_reg[l]   <= z0;
                    cneg_reg[l] <= 1'b0;
                end
            end
            else if (cmd.cordic_step)
            begin
                if (!cz_reg[l][CW-1])
                begin
                    cx_reg[l] <= cx_reg[l] - (cy_reg[l] >>> cmd.idx);
                    cy_reg[l] <= cy_reg[l] + (cx_reg[l] >>> cmd.idx);
                    cz_reg[l] <= cz_reg[l] - at;
                end
                else
                begin
                    cx_reg[l] <= cx_reg[l] + (cy_reg[l] >>> cmd.idx);
                    cy_reg[l] <= cy_reg[l] - (cx_reg[l] >>> cmd.idx);
                    cz_reg[l] <= cz_reg[l] + at;
                end
            end
        end
    end

    // Sine and cosine capture
    always_ff @(posedge clk)
    begin
        if (cmd.sc_load)
        begin
            for (int l = 0; l < 3; l++)
            begin
                cos_reg[l] <= round_sc(cneg_reg[l] ? -cx_reg[l] : cx_reg[l]);
                sin_reg[l] <= round_sc(cneg_reg[l] ? -cy_reg[l] : cy_reg[l]);
            end
        end
    end

    // Multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.mul_pose)
        begin
            case (cmd.mul_sel)
                4'd0:    begin mul_a = XW'(sin_reg[0]);  mul_b = sin_reg[1]; end
                4'd1:    begin mul_a = XW'(cos_reg[0]);  mul_b = sin_reg[1]; end
                4'd2:    begin mul_a = XW'(cos_reg[1]);  mul_b = cos_reg[2]; end
                4'd3:    begin mul_a = XW'(cos_reg[1]);  mul_b = sin_reg[2]; end
                4'd4:    begin mul_a = XW'(cos_reg[0]);  mul_b = sin_reg[2]; end
                4'd5:    begin mul_a = XW'(prod_reg[0]); mul_b = cos_reg[2]; end
                4'd6:    begin mul_a = XW'(cos_reg[0]);  mul_b = cos_reg[2]; end
                4'd7:    begin mul_a = XW'(prod_reg[0]); mul_b = sin_reg[2]; end
                4'd8:    begin mul_a = XW'(sin_reg[0]);  mul_b = cos_reg[1]; end
                4'd9:    begin mul_a = XW'(sin_reg[0]);  mul_b = sin_reg[2]; end
                4'd10:   begin mul_a = XW'(prod_reg[1]); mul_b = cos_reg[2]; end
                4'd11:   begin mul_a = XW'(sin_reg[0]);  mul_b = cos_reg[2]; end
                4'd12:   begin mul_a = XW'(prod_reg[1]); mul_b = sin_reg[2]; end
                4'd13:   begin mul_a = XW'(cos_reg[0]);  mul_b = cos_reg[1]; end
                default: begin mul_a = '0;               mul_b = '0;         end
            endcase
        end
        else
        begin
            // point: entry k pairs with coordinate column k mod 3
            case (cmd.mul_sel)
                4'd0, 4'd3, 4'd6: mul_a = pt_reg[0];
                4'd1, 4'd4, 4'd7: mul_a = pt_reg[1];
                default:          mul_a = pt_reg[2];
            endcase
            if (cmd.mul_sel < 4'd9)
                mul_b = rot_reg[cmd.mul_sel];
        end
    end

    assign mul_next = mul_a * mul_b;
    assign mul_rnd  = (mul_reg + RND_MP) >>> F;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            mul_reg <= mul_next;
    end

    // Pose product write-back
    always_ff @(posedge clk)
    begin
        if (cmd.wb_en)
            prod_reg[cmd.wb_sel] <= EW'(mul_rnd);
    end

    // Rotation matrix and translation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                rot_reg[k] <= (k % 4 == 0) ? EW'(ONE_E) : '0;
            for (int k = 0; k < 3; k++)
                trans_reg[k] <= '0;
        end
        else if (cmd.pose_commit)
        begin
            rot_reg[0] <= clamp_e((EW + 1)'(prod_reg[2]));
            rot_reg[1] <= clamp_e(-(EW + 1)'(prod_reg[3]));
            rot_reg[2] <= clamp_e((EW + 1)'(sin_reg[1]));
            rot_reg[3] <= clamp_e((EW + 1)'(prod_reg[4]) + (EW + 1)'(prod_reg[5]));
            rot_reg[4] <= clamp_e((EW + 1)'(prod_reg[6]) - (EW + 1)'(prod_reg[7]));
            rot_reg[5] <= clamp_e(-(EW + 1)'(prod_reg[8]));
            rot_reg[6] <= clamp_e((EW + 1)'(prod_reg[9]) - (EW + 1)'(prod_reg[10]));
            rot_reg[7] <= clamp_e((EW + 1)'(prod_reg[11]) + (EW + 1)'(prod_reg[12]));
            rot_reg[8] <= clamp_e((EW + 1)'(prod_reg[13]));
            for (int k = 0; k < 3; k++)
                trans_reg[k] <= pt_reg[k];
        end
    end

    // Row accumulation
    assign mul_ext = AW'(mul_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.acc_en)
            acc_reg <= cmd.acc_first ? mul_ext : acc_reg + mul_ext;
    end

    // Row finish: round, translate, saturate
    always_comb
    begin
        fin_val = ((acc_reg + RND_AC) >>> F) + AW'(trans_reg[cmd.fin_row]);
        fin_ovf = 1'b1;
        if (fin_val > MAX_OUT)
            fin_sat = XW'(MAX_OUT);
        else if (fin_val < MIN_OUT)
            fin_sat = XW'(MIN_OUT);
        else
        begin
            fin_sat = XW'(fin_val);
            fin_ovf = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_en)
        begin
            res_reg[cmd.fin_row] <= fin_sat;
            ovf_reg <= (cmd.fin_row == 2'd0) ? fin_ovf : (ovf_reg | fin_ovf);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.publish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_x_reg    <= res_reg[0];
            out_y_reg    <= res_reg[1];
            out_z_reg    <= res_reg[2];
            overflow_reg <= ovf_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign overflow  = overflow_reg;

endmodule

// ===== sv/euler_rigid_point_transform_core.sv =====
// Rigid point transform with an XYZ Euler pose. A pose beat (mode 0) runs
// three CORDIC lanes in step through CORDIC_STEPS rotation steps, then
// builds R = Rx*Ry*Rz on one shared multiplier; it keeps the block busy
// and gives no result. A point beat (mode 1) takes its nine matrix
// products one per cycle on the same multiplier; the next beat is accepted
// only once the previous one is done. The result waits in an output
// register while the next beat is accepted. Coordinates are Q16.16,
// matrix entries Q1.F with F = MATRIX_FRAC_BITS; results saturate and
// set overflow.
module euler_rigid_point_transform_core #(
    parameter int CORDIC_STEPS     = erpt_pkg::CORDIC_STEPS_DEF,
    parameter int MATRIX_FRAC_BITS = erpt_pkg::MATRIX_FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    erpt_item_if.sink            item,
    erpt_result_if.source        result
);

    erpt_pkg::cmd_t    cmd;
    erpt_pkg::status_t status;

    erpt_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_mode  (item.mode),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    erpt_datapath #(
        .MATRIX_FRAC_BITS (MATRIX_FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .coord_x       (item.coord_x),
        .coord_y       (item.coord_y),
        .coord_z       (item.coord_z),
        .angle_about_x (item.angle_about_x),
        .angle_about_y (item.angle_about_y),
        .angle_about_z (item.angle_about_z),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .out_x         (result.out_x),
        .out_y         (result.out_y),
        .out_z         (result.out_z),
        .overflow      (result.overflow)
    );

endmodule

// ===== sv/erpt_checker.sv =====
module erpt_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [erpt_pkg::COORD_W-1:0] out_x,
    input logic signed [erpt_pkg::COORD_W-1:0] out_y,
    input logic signed [erpt_pkg::COORD_W-1:0] out_z,
    input logic                                overflow
);

    localparam logic signed [erpt_pkg::COORD_W-1:0] SMAX = 32'sh7fffffff;
    localparam logic signed [erpt_pkg::COORD_W-1:0] SMIN = 32'sh80000000;

    // A held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before taken");

    // One beat at a time: an accepted beat makes the block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

    // A new result appears only as the block finishes a point
    a_publish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work");

    // Overflow means some coordinate sits at a limit
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> (out_x == SMAX || out_x == SMIN ||
                                   out_y == SMAX || out_y == SMIN ||
                                   out_z == SMAX || out_z == SMIN))
        else $error("overflow without saturated coordinate");

endmodule

bind euler_rigid_point_transform_core erpt_checker u_erpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_x     (result.out_x),
    .out_y     (result.out_y),
    .out_z     (result.out_z),
    .overflow  (result.overflow)
);
